[rtl/bank_switch_mapper_irq_timer_assert.svh]
// ----------------------------------------------------------------------------
// bank switch mapper assertion macros
// concurrent check macros, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MAPPER_IRQ_TIMER_ASSERT_SVH
`define BANK_SWITCH_MAPPER_IRQ_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
`define BSM_ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("bsm check failed");
`define BSM_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("bsm check failed");
`else
`define BSM_ASSERT_IMPLIES(label, a, b)
`define BSM_ASSERT_NEXT(label, a, b)
`endif

`endif

[rtl/bsm_pkg.sv]
// ----------------------------------------------------------------------------
// bsm_pkg
// shared types, codes and constants of the bank switch mapper
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int PATTERN_SLOTS = 8;
  localparam int PROGRAM_SLOTS = 3;
  localparam int DIV_STEPS     = 9;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MODE_WRITE    = 2'd0,
    MODE_CPU_READ = 2'd1,
    MODE_PAT_READ = 2'd2,
    MODE_TICK     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_PRG_ROM  = 3'd1,
    TGT_WRAM     = 3'd2,
    TGT_OPEN_BUS = 3'd3,
    TGT_PATTERN  = 3'd4
  } target_t;

  localparam logic [3:0] REG_PAT_FIRST  = 4'd0;
  localparam logic [3:0] REG_PAT_LAST   = 4'd7;
  localparam logic [3:0] REG_LOW_WINDOW = 4'd8;
  localparam logic [3:0] REG_PRG_FIRST  = 4'd9;
  localparam logic [3:0] REG_PRG_LAST   = 4'd11;
  localparam logic [3:0] REG_MIRROR     = 4'd12;
  localparam logic [3:0] REG_IRQ        = 4'd13;
  localparam logic [3:0] REG_CNT_LO     = 4'd14;
  localparam logic [3:0] REG_CNT_HI     = 4'd15;

  localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [1:0] CFG_WRAM      = 2'd2;

  localparam logic [15:0] WRITE_SPLIT   = 16'hA000;
  localparam logic [15:0] CPU_PRG_BASE  = 16'h8000;
  localparam logic [15:0] CPU_WRAM_BASE = 16'h6000;

  typedef struct packed {
    logic latch;
    logic exec;
    logic div_step;
    logic form;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

[rtl/bsm_ctrl.sv]
// ----------------------------------------------------------------------------
// bsm_ctrl
// request sequencer: accept, execute, bank reduction steps, result hand-off
// ----------------------------------------------------------------------------
`include "bank_switch_mapper_irq_timer_assert.svh"

module bsm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  bsm_pkg::sts_t sts,
  output bsm_pkg::cmd_t cmd
);
  import bsm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_FORM = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FORM;
      end
      S_FORM: begin
        cmd.form   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `BSM_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, state == S_EXEC)
  `BSM_ASSERT_NEXT(a_div_form, state == S_DIV && sts.div_last, state == S_FORM)
  `BSM_ASSERT_NEXT(a_load_valid, state == S_OUT && out_free, m_tvalid && state == S_IDLE)

endmodule

[rtl/bsm_dp.sv]
// ----------------------------------------------------------------------------
// bsm_dp
// mapper registers, cycle timer, address translation and remainder unit
// ----------------------------------------------------------------------------
module bsm_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    s_tuser,
  input  logic [39:0]   s_tdata,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [10:0]   cfg_data,
  input  bsm_pkg::cmd_t cmd,
  output bsm_pkg::sts_t sts,
  output logic [31:0]   m_tdata,
  output logic [2:0]    m_tuser
);
  import bsm_pkg::*;

  // configuration
  logic [8:0]  prg_bank_count;
  logic [10:0] chr_bank_count;
  logic        wram_present;

  // captured request
  mode_t       it_mode;
  logic [15:0] it_addr;
  logic [7:0]  it_data;
  logic [15:0] it_cycles;

  // mapper state
  logic [3:0]  selected_register;
  logic [7:0]  pattern_banks [PATTERN_SLOTS];
  logic [5:0]  program_banks [PROGRAM_SLOTS];
  logic [5:0]  low_window_bank;
  logic        low_window_is_ram;
  logic        count_enable;
  logic        irq_enable;
  logic [15:0] cycle_counter;
  logic [1:0]  mirror_mode;
  logic        irq_flag;

  // result
  target_t     res_target;
  logic [21:0] res_addr;
  logic        res_raise;
  logic        res_ack;

  // remainder unit
  logic [8:0]           div_q;
  logic [10:0]          div_rem;
  logic [10:0]          div_d;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [11:0]          trial;

  logic [8:0]  prg_n;
  logic [1:0]  slot;
  logic [1:0]  prg_idx;
  logic [8:0]  dividend;
  logic [10:0] divisor;
  logic        need_div;
  logic        in_prg;
  logic        in_wram;

  assign prg_n   = (prg_bank_count == 9'd0) ? 9'd1 : prg_bank_count;
  assign slot    = it_addr[14:13];
  assign prg_idx = 2'(selected_register - REG_PRG_FIRST);
  assign in_prg  = it_addr >= CPU_PRG_BASE;
  assign in_wram = !in_prg && (it_addr >= CPU_WRAM_BASE);
  assign trial   = {div_rem, div_q[8]};

  always_comb begin
    dividend = '0;
    divisor  = {2'b00, prg_n};
    need_div = 1'b0;
    case (it_mode)
      MODE_CPU_READ: begin
        if (in_prg) begin
          need_div = 1'b1;
          if (slot == 2'd3) dividend = prg_n - 9'd1;
          else dividend = {3'b000, program_banks[slot]};
        end else if (in_wram && !low_window_is_ram) begin
          need_div = 1'b1;
          dividend = {3'b000, low_window_bank};
        end
      end
      MODE_PAT_READ: begin
        divisor  = chr_bank_count;
        dividend = {1'b0, pattern_banks[it_addr[12:10]]};
        need_div = (chr_bank_count != 11'd0);
      end
      default: need_div = 1'b0;
    endcase
  end

  assign sts.need_div = need_div;
  assign sts.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= 9'd16;
      chr_bank_count <= 11'd0;
      wram_present   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_COUNT: prg_bank_count <= cfg_data[8:0];
        CFG_CHR_COUNT: chr_bank_count <= cfg_data;
        CFG_WRAM:      wram_present   <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_mode   <= mode_t'(s_tuser);
      it_addr   <= s_tdata[15:0];
      it_data   <= s_tdata[23:16];
      it_cycles <= s_tdata[39:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_register <= '0;
      for (int i = 0; i < PATTERN_SLOTS; i++) pattern_banks[i] <= 8'(i);
      for (int i = 0; i < PROGRAM_SLOTS; i++) program_banks[i] <= 6'(i);
      low_window_bank   <= '0;
      low_window_is_ram <= 1'b0;
      count_enable      <= 1'b0;
      irq_enable        <= 1'b0;
      cycle_counter     <= '0;
      mirror_mode       <= '0;
      irq_flag          <= 1'b0;
    end else if (cmd.exec) begin
      if (it_mode == MODE_WRITE) begin
        if (it_addr < WRITE_SPLIT) begin
          selected_register <= it_data[3:0];
        end else begin
          unique case (selected_register) inside
            [REG_PAT_FIRST:REG_PAT_LAST]: pattern_banks[selected_register[2:0]] <= it_data;
            REG_LOW_WINDOW: begin
              low_window_bank   <= it_data[5:0];
              low_window_is_ram <= it_data[6];
            end
            [REG_PRG_FIRST:REG_PRG_LAST]: program_banks[prg_idx] <= it_data[5:0];
            REG_MIRROR: mirror_mode <= it_data[1:0];
            REG_IRQ: begin
              count_enable <= it_data[7];
              irq_enable   <= it_data[0];
              irq_flag     <= 1'b0;
            end
            REG_CNT_LO: cycle_counter[7:0]  <= it_data;
            REG_CNT_HI: cycle_counter[15:8] <= it_data;
            default: ;
          endcase
        end
      end else if (it_mode == MODE_TICK && count_enable) begin
        cycle_counter <= cycle_counter - it_cycles;
        if (it_cycles > cycle_counter && irq_enable) irq_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_target <= TGT_NONE;
      res_addr   <= '0;
      res_raise  <= 1'b0;
      res_ack    <= 1'b0;
      div_q      <= dividend;
      div_rem    <= '0;
      div_d      <= divisor;
      div_cnt    <= DIV_CNT_W'(DIV_STEPS - 1);
      case (it_mode)
        MODE_WRITE: begin
          res_ack <= (it_addr >= WRITE_SPLIT) && (selected_register == REG_IRQ) && irq_flag;
        end
        MODE_CPU_READ: begin
          if (in_prg) begin
            res_target <= TGT_PRG_ROM;
          end else if (in_wram) begin
            if (!low_window_is_ram) begin
              res_target <= TGT_PRG_ROM;
            end else if (wram_present) begin
              res_target <= TGT_WRAM;
              res_addr   <= {9'd0, it_addr[12:0]};
            end else begin
              res_target <= TGT_OPEN_BUS;
            end
          end
        end
        MODE_PAT_READ: begin
          res_target <= TGT_PATTERN;
          res_addr   <= {9'd0, it_addr[12:0]};
        end
        default: begin
          res_raise <= count_enable && irq_enable && (it_cycles > cycle_counter);
        end
      endcase
    end else begin
      if (cmd.div_step) begin
        div_q   <= {div_q[7:0], 1'b0};
        div_cnt <= div_cnt - 1'b1;
        if (trial >= {1'b0, div_d}) div_rem <= 11'(trial - {1'b0, div_d});
        else div_rem <= trial[10:0];
      end
      if (cmd.form) begin
        if (res_target == TGT_PATTERN) res_addr <= {1'b0, div_rem, it_addr[9:0]};
        else res_addr <= {div_rem[8:0], it_addr[12:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {6'd0, res_ack, res_raise, mirror_mode, res_addr};
      m_tuser <= res_target;
    end
  end

endmodule

[rtl/bank_switch_mapper_irq_timer.sv]
// ----------------------------------------------------------------------------
// bank_switch_mapper_irq_timer
// cartridge bank switch mapper with a 16-bit down-counting irq timer
// ----------------------------------------------------------------------------
// A request holds the block from the accepting clock until its result is loaded
// into the output register. Register writes, ticks, reads below the window and
// work-ram or unbanked pattern reads pass through accept, execute and output
// load; banked program or pattern reads also take the reduction steps and the
// form step, since the bank number is reduced by a nine-step shift-subtract
// remainder unit. The next request is accepted as soon as the previous result
// has moved into the output register, even while it waits there; a result that
// finds the output register still full holds the block until that one is taken.
module bank_switch_mapper_irq_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // address[15:0], data[23:16], cycles[39:24]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // mem_address[21:0], mirroring[23:22],
                                 // irq_raise[24], irq_ack[25], zero[31:26]
  output logic [2:0]  m_tuser,   // target[2:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import bsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
